### rtl/spx_pkg.sv
// ----------------------------------------------------------------------------
// spx_pkg
// Shared types and constants of the strided axis prefix sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package spx_pkg;

  localparam int MAX_INNER = 256;
  localparam int INNER_AW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int IE_W      = INNER_AW + 1;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 24;
  localparam int DIM_W     = 16;
  localparam int INNER_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAB_COUNT  = 3'd0,
    CFG_AXIS_LENGTH = 3'd1,
    CFG_INNER_SIZE  = 3'd2,
    CFG_EXCLUSIVE   = 3'd3,
    CFG_EXTEND      = 3'd4,
    CFG_REVERSE     = 3'd5
  } spx_cfg_idx_e;

  // One accepted element's position and addressing, taken at acceptance
  typedef struct packed {
    logic [INNER_AW-1:0] pos;
    logic                first_row;
    logic                last_step;
    logic                last_tensor;
    logic                emit_prior;
    logic                extend;
    logic [ADDR_W-1:0]   addr_main;
    logic [ADDR_W-1:0]   addr_second;
  } spx_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              done;
  } spx_result_t;

endpackage

`default_nettype wire

### rtl/strided_axis_prefix_sum.sv
// ----------------------------------------------------------------------------
// strided_axis_prefix_sum
// Prefix sum along one axis of an int32 tensor, one running sum per inner
// position kept in a synchronous memory.
// ----------------------------------------------------------------------------
// One element is taken per clock cycle unless the output stalls; an element
// passes the stage-1 register and then the output buffer. In extend mode the
// last axis row gives two beats per element, and the input is held while the
// first is sent. The rate is set by one read-add-write of the running-sum
// memory per element; a write into the same entry as the next read is
// forwarded. After reset and any mapped register write the input waits while
// the row span product forms, and the scan restarts at its first element.
`default_nettype none

module strided_axis_prefix_sum (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [spx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [spx_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // element stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [31:0]                    s_axis_tdata_i,  // [31:0] element_value
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [55:0]                         m_axis_tdata_o,  // [31:0] sum_value, [55:32] out_address
  output logic                                m_axis_tlast_o,  // last_of_run
  output logic [0:0]                          m_axis_tuser_o   // [0] tensor_done
);

  spx_pkg::spx_item_t   item, s1_item_q;
  spx_pkg::spx_result_t res0, res1, res_out;
  logic                 gen_ready, accept, s1_valid_q, s1_adv, can_load;
  logic                 s1_fwd_q;
  logic [spx_pkg::DATA_W-1:0] s1_x_q, s1_fwd_data_q, rd_data, prior, total;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = gen_ready & (~s1_valid_q | s1_adv);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign s1_adv          = s1_valid_q & can_load;

  spx_addr_gen u_addr_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (accept),
    .ready_o     (gen_ready),
    .item_o      (item)
  );

  spx_sum_ram u_sum_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (item.pos),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_item_q.pos),
    .wr_data_i (total)
  );

  always_comb begin
    prior = s1_item_q.first_row ? '0 : (s1_fwd_q ? s1_fwd_data_q : rd_data);
    total = prior + s1_x_q;

    res0.sum  = s1_item_q.emit_prior ? prior : total;
    res0.addr = s1_item_q.addr_main;
    res0.last = ~s1_item_q.extend | ~s1_item_q.last_step;
    res0.done = ~s1_item_q.extend & s1_item_q.last_tensor;

    res1.sum  = total;
    res1.addr = s1_item_q.addr_second;
    res1.last = 1'b1;
    res1.done = s1_item_q.last_tensor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the element; forward a write to the same entry landing this edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q     <= item;
      s1_x_q        <= s_axis_tdata_i;
      s1_fwd_q      <= s1_adv & (s1_item_q.pos == item.pos);
      s1_fwd_data_q <= total;
    end
  end

  spx_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s1_adv),
    .res0_i          (res0),
    .res1_i          (res1),
    .two_i           (s1_item_q.extend & s1_item_q.last_step),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .res_o           (res_out)
  );

  assign m_axis_tdata_o = {res_out.addr, res_out.sum};
  assign m_axis_tlast_o = res_out.last;
  assign m_axis_tuser_o = res_out.done;

endmodule

`default_nettype wire

### rtl/spx_sum_ram.sv
// ----------------------------------------------------------------------------
// spx_sum_ram
// Running-sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_sum_ram (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [spx_pkg::INNER_AW-1:0]  rd_addr_i,
  output logic      [spx_pkg::DATA_W-1:0]    rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [spx_pkg::INNER_AW-1:0]  wr_addr_i,
  input  wire logic [spx_pkg::DATA_W-1:0]    wr_data_i
);

  logic [spx_pkg::DATA_W-1:0] mem_q [spx_pkg::MAX_INNER];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/spx_addr_gen.sv
// ----------------------------------------------------------------------------
// spx_addr_gen
// Configuration registers, scan position counters and output addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_addr_gen (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [spx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [spx_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  wire logic                           adv_i,
  output logic                                ready_o,
  output spx_pkg::spx_item_t                  item_o
);

  localparam int AW = spx_pkg::ADDR_W;

  logic [spx_pkg::DIM_W-1:0]   slab_count_q, axis_length_q;
  logic [spx_pkg::INNER_W-1:0] inner_size_q;
  logic                        excl_q, ext_q, rev_q;

  logic [spx_pkg::INNER_AW-1:0] pos_q;
  logic [spx_pkg::DIM_W-1:0]    step_q, slab_q;
  logic [AW-1:0]                slab_base_q, row_off_q, li_q;
  logic [1:0]                   settle_q;

  logic [spx_pkg::DIM_W-1:0] se, le;
  logic [spx_pkg::IE_W-1:0]  ie;
  logic [AW-1:0]             ie_a, start_off, span, sec_off;
  logic                      m_excl, m_ext, m_rev, both;
  logic                      pos_last, step_last, slab_last;

  always_comb begin
    se = (slab_count_q == '0) ? spx_pkg::DIM_W'(1) : slab_count_q;
    le = (axis_length_q == '0) ? spx_pkg::DIM_W'(1) : axis_length_q;
    if (inner_size_q == '0) begin
      ie = spx_pkg::IE_W'(1);
    end else if (32'(inner_size_q) > spx_pkg::MAX_INNER) begin
      ie = spx_pkg::IE_W'(spx_pkg::MAX_INNER);
    end else begin
      ie = spx_pkg::IE_W'(inner_size_q);
    end
    ie_a = AW'(ie);

    both   = excl_q & ext_q;
    m_excl = excl_q & ~ext_q;
    m_ext  = ext_q & ~excl_q;
    m_rev  = rev_q & ~both;

    // Row offset of the first scanned row, slab span and the extra row offset
    start_off = m_rev ? (m_ext ? li_q : li_q - ie_a) : '0;
    span      = m_ext ? li_q + ie_a : li_q;
    sec_off   = m_rev ? '0 : li_q;

    pos_last  = (pos_q == spx_pkg::INNER_AW'(ie - spx_pkg::IE_W'(1)));
    step_last = (step_q == le - spx_pkg::DIM_W'(1));
    slab_last = (slab_q == se - spx_pkg::DIM_W'(1));

    item_o.pos         = pos_q;
    item_o.first_row   = (step_q == '0);
    item_o.last_step   = step_last;
    item_o.last_tensor = step_last & pos_last & slab_last;
    item_o.emit_prior  = m_excl | m_ext;
    item_o.extend      = m_ext;
    item_o.addr_main   = slab_base_q + row_off_q + AW'(pos_q);
    item_o.addr_second = slab_base_q + sec_off + AW'(pos_q);
  end

  assign ready_o = (settle_q == '0);

  // Row span of one axis step: only changes with configuration
  always_ff @(posedge clk_i) begin
    li_q <= AW'(AW'(le) * ie_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_count_q  <= spx_pkg::DIM_W'(1);
      axis_length_q <= spx_pkg::DIM_W'(1);
      inner_size_q  <= spx_pkg::INNER_W'(1);
      excl_q        <= 1'b0;
      ext_q         <= 1'b0;
      rev_q         <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spx_pkg::CFG_SLAB_COUNT:  slab_count_q  <= cfg_data_i;
        spx_pkg::CFG_AXIS_LENGTH: axis_length_q <= cfg_data_i;
        spx_pkg::CFG_INNER_SIZE:  inner_size_q  <= cfg_data_i[spx_pkg::INNER_W-1:0];
        spx_pkg::CFG_EXCLUSIVE:   excl_q        <= cfg_data_i[0];
        spx_pkg::CFG_EXTEND:      ext_q         <= cfg_data_i[0];
        spx_pkg::CFG_REVERSE:     rev_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_valid_i && (cfg_index_i <= spx_pkg::CFG_IDX_W'(spx_pkg::CFG_REVERSE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      step_q      <= '0;
      slab_q      <= '0;
      slab_base_q <= '0;
      row_off_q   <= '0;
      settle_q    <= 2'd2;
    end else if (cfg_hit) begin
      // restart the tensor and let the span product settle
      pos_q       <= '0;
      step_q      <= '0;
      slab_q      <= '0;
      slab_base_q <= '0;
      settle_q    <= 2'd2;
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 2'd1;
      if (settle_q == 2'd1) begin
        row_off_q <= start_off;
      end
    end else if (adv_i) begin
      if (pos_last) begin
        pos_q <= '0;
        if (step_last) begin
          step_q    <= '0;
          row_off_q <= start_off;
          if (slab_last) begin
            slab_q      <= '0;
            slab_base_q <= '0;
          end else begin
            slab_q      <= slab_q + spx_pkg::DIM_W'(1);
            slab_base_q <= slab_base_q + span;
          end
        end else begin
          step_q    <= step_q + spx_pkg::DIM_W'(1);
          row_off_q <= m_rev ? row_off_q - ie_a : row_off_q + ie_a;
        end
      end else begin
        pos_q <= pos_q + spx_pkg::INNER_AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/spx_out_buf.sv
// ----------------------------------------------------------------------------
// spx_out_buf
// Output register holding up to two results of one element, sent in order.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire spx_pkg::spx_result_t res0_i,
  input  wire spx_pkg::spx_result_t res1_i,
  input  wire logic                 two_i,
  output logic                      can_load_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output spx_pkg::spx_result_t      res_o
);

  logic                 valid_q, phase_q, two_q;
  spx_pkg::spx_result_t r0_q, r1_q;
  logic                 pop, drain;

  assign pop        = valid_q & m_axis_tready_i;
  assign drain      = pop & (~two_q | phase_q);
  assign can_load_o = ~valid_q | drain;

  assign m_axis_tvalid_o = valid_q;
  assign res_o           = phase_q ? r1_q : r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
      two_q   <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      phase_q <= 1'b0;
      two_q   <= two_i;
    end else if (drain) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (pop) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r0_q <= res0_i;
      r1_q <= res1_i;
    end
  end

endmodule

`default_nettype wire

### rtl/spx_checker.sv
// ----------------------------------------------------------------------------
// spx_checker
// Port-level checks of the strided axis prefix sum, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [spx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [55:0]                    m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o,
  input wire logic [0:0]                     m_axis_tuser_o
);

  // a stalled result beat stays offered
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat withdrawn while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // the tensor can only end on the final beat of an element
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("tensor end without end of run");

  // a write to a mapped register restarts the scan: no element is taken just after it
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
      (cfg_index_i <= spx_pkg::CFG_IDX_W'(spx_pkg::CFG_REVERSE)) |=> !s_axis_tready_o)
    else $error("element taken right after a register write");

endmodule

bind strided_axis_prefix_sum spx_checker u_spx_checker (.*);

`default_nettype wire

### verif/tb_strided_axis_prefix_sum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strided_axis_prefix_sum
// Self-checking bench: streams int32 elements through the block under
// assorted geometries and scan modes and checks every result beat (sum,
// address, run and tensor flags) against an in-bench running-sum predictor.
// ----------------------------------------------------------------------------
module tb_strided_axis_prefix_sum;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 2000;
  // indexes past the register map, written to prove they are ignored
  localparam logic [spx_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
  localparam logic [spx_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [spx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spx_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [31:0]                   s_data = '0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [55:0]                   m_data;
  logic                          m_last;
  logic [0:0]                    m_user;

  strided_axis_prefix_sum u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register mirror, running sums and scan position
  // --------------------------------------------------------------------------
  logic [15:0] m_slabs = 16'd1;
  logic [15:0] m_rows = 16'd1;
  logic [8:0]  m_inner = 9'd1;
  logic        m_excl = 1'b0;
  logic        m_ext = 1'b0;
  logic        m_rev = 1'b0;
  logic [31:0] acc_sums [spx_pkg::MAX_INNER];
  int unsigned pos_inner = 0;
  int unsigned pos_step = 0;
  int unsigned pos_slab = 0;

  logic [31:0] element_q [$];
  spx_pkg::spx_result_t pending_sums [$];
  spx_pkg::spx_result_t observed_sums [$];

  int err_count = 0;
  int total_fed = 0;
  int idle_level = 0;
  int src_wait = 0;
  int sink_wait = 0;
  int stall_cycles = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  // address wraps at 2^24 output elements, so only the low bits survive
  function automatic logic [spx_pkg::ADDR_W-1:0] flat_index(input longint unsigned slab,
      input longint unsigned rows, input longint unsigned row,
      input longint unsigned inner, input longint unsigned pos);
    longint unsigned a;
    a = slab * rows * inner + row * inner + pos;
    return a[spx_pkg::ADDR_W-1:0];
  endfunction

  function automatic void accumulate_element(input logic [31:0] x);
    int unsigned ns, nl, ni;
    bit both, excl_eff, ext_eff, rev_eff, last_step, last_tensor;
    logic [31:0] prior, total;
    spx_pkg::spx_result_t r;
    ns = (m_slabs == 0) ? 1 : m_slabs;
    nl = (m_rows == 0) ? 1 : m_rows;
    ni = (m_inner == 0) ? 1 :
         ((m_inner > spx_pkg::MAX_INNER) ? spx_pkg::MAX_INNER : m_inner);
    both     = m_excl && m_ext;
    excl_eff = m_excl && !m_ext;
    ext_eff  = m_ext && !m_excl;
    rev_eff  = m_rev && !both;

    // a row restarts its sum at the first axis step
    prior = (pos_step == 0) ? 32'd0 : acc_sums[pos_inner];
    total = prior + x;
    acc_sums[pos_inner] = total;
    last_step   = (pos_step == nl - 1);
    last_tensor = last_step && (pos_inner == ni - 1) && (pos_slab == ns - 1);

    if (ext_eff) begin
      r.sum  = prior;
      r.addr = flat_index(pos_slab, nl + 1, rev_eff ? nl - pos_step : pos_step, ni, pos_inner);
      r.last = !last_step;
      r.done = 1'b0;
      pending_sums.push_back(r);
      if (last_step) begin
        // extra row: total goes to the far end in forward order, row 0 in reverse
        r.sum  = total;
        r.addr = flat_index(pos_slab, nl + 1, rev_eff ? 0 : nl, ni, pos_inner);
        r.last = 1'b1;
        r.done = last_tensor;
        pending_sums.push_back(r);
      end
    end else begin
      r.sum  = excl_eff ? prior : total;
      r.addr = flat_index(pos_slab, nl, rev_eff ? nl - 1 - pos_step : pos_step, ni, pos_inner);
      r.last = 1'b1;
      r.done = last_tensor;
      pending_sums.push_back(r);
    end

    pos_inner++;
    if (pos_inner >= ni) begin
      pos_inner = 0;
      pos_step++;
      if (pos_step >= nl) begin
        pos_step = 0;
        pos_slab++;
        if (pos_slab >= ns) pos_slab = 0;
      end
    end
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 15);
      3: return 32'd0 - $urandom_range(1, 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic bit roll_gap();
    if (idle_level == 0) return 1'b0;
    return $urandom_range(0, (idle_level == 1) ? 15 : 3) == 0;
  endfunction

  // --------------------------------------------------------------------------
  // Element driver: drives from element_q, predicts on every accepted beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : element_driver
    if (rst_ni) begin
      if (s_valid && s_ready) accumulate_element(s_data);
      if (!s_valid || s_ready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_valid <= 1'b0;
        end else if (element_q.size() == 0) begin
          s_valid <= 1'b0;
        end else if (roll_gap()) begin
          src_wait = $urandom_range(0, 8);
          s_valid <= 1'b0;
        end else begin
          s_valid <= 1'b1;
          s_data  <= element_q.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: captures beats and drives back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    spx_pkg::spx_result_t got;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got.sum  = m_data[31:0];
        got.addr = m_data[55:32];
        got.last = m_last;
        got.done = m_user[0];
        observed_sums.push_back(got);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        // hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        sink_wait = LONG_HOLD;
        m_ready <= 1'b0;
      end else if (roll_gap()) begin
        sink_wait = $urandom_range(0, 8);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // compare at the falling edge, once both sides of the rising edge are settled
  always @(negedge clk_i) begin : sum_checker
    spx_pkg::spx_result_t got, want;
    while (observed_sums.size() > 0) begin
      got = observed_sums.pop_front();
      if (pending_sums.size() == 0) begin
        $error("result beat with nothing pending: sum %h addr %h", got.sum, got.addr);
        err_count++;
      end else begin
        want = pending_sums.pop_front();
        if (got.sum !== want.sum) begin
          $error("sum_value: expected %h, got %h", want.sum, got.sum);
          err_count++;
        end
        if (got.addr !== want.addr) begin
          $error("out_address: expected %h, got %h", want.addr, got.addr);
          err_count++;
        end
        if (got.last !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, got.last);
          err_count++;
        end
        if (got.done !== want.done) begin
          $error("tensor_done: expected %b, got %b", want.done, got.done);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_strided_axis_prefix_sum NOT OK");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [spx_pkg::CFG_IDX_W-1:0] idx,
      input logic [spx_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      spx_pkg::CFG_SLAB_COUNT:  m_slabs = val;
      spx_pkg::CFG_AXIS_LENGTH: m_rows = val;
      spx_pkg::CFG_INNER_SIZE:  m_inner = val[spx_pkg::INNER_W-1:0];
      spx_pkg::CFG_EXCLUSIVE:   m_excl = val[0];
      spx_pkg::CFG_EXTEND:      m_ext = val[0];
      spx_pkg::CFG_REVERSE:     m_rev = val[0];
      default:                  return;
    endcase
    pos_inner = 0;
    pos_step  = 0;
    pos_slab  = 0;
  endtask

  // mode registers carry random upper bits; only bit 0 counts
  task automatic configure(input logic [15:0] slabs, input logic [15:0] rows,
      input logic [15:0] inner, input bit excl, input bit ext, input bit rev);
    write_reg(spx_pkg::CFG_SLAB_COUNT, slabs);
    write_reg(spx_pkg::CFG_AXIS_LENGTH, rows);
    write_reg(spx_pkg::CFG_INNER_SIZE, inner);
    write_reg(spx_pkg::CFG_EXCLUSIVE, {15'($urandom()), excl});
    write_reg(spx_pkg::CFG_EXTEND, {15'($urandom()), ext});
    write_reg(spx_pkg::CFG_REVERSE, {15'($urandom()), rev});
  endtask

  task automatic feed_random(input int n, input int idle);
    @(negedge clk_i);
    idle_level = idle;
    repeat (n) element_q.push_back(pick_element());
    total_fed += n;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (element_q.size() != 0 || s_valid || pending_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ns, nr, ni, size, n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: every element is a whole tensor
    @(negedge clk_i);
    element_q.push_back(32'h7fff_ffff);
    element_q.push_back(32'h8000_0000);
    element_q.push_back(32'hffff_ffff);
    element_q.push_back(32'h0000_0000);
    wait_drained();

    // extend forward, with a wrapping sum
    configure(16'd1, 16'd2, 16'd2, 1'b0, 1'b1, 1'b0);
    @(negedge clk_i);
    element_q.push_back(32'h7fff_ffff);
    element_q.push_back(32'h8000_0000);
    element_q.push_back(32'h0000_0001);
    element_q.push_back(32'hffff_ffff);
    wait_drained();

    // extend reverse
    configure(16'd1, 16'd2, 16'd2, 1'b0, 1'b1, 1'b1);
    @(negedge clk_i);
    element_q.push_back(32'h0000_0005);
    element_q.push_back(32'hffff_fffd);
    element_q.push_back(32'h7fff_ffff);
    element_q.push_back(32'h8000_0000);
    wait_drained();

    // exclusive with extend falls back to forward inclusive, reverse ignored
    configure(16'd2, 16'd2, 16'd1, 1'b1, 1'b1, 1'b1);
    @(negedge clk_i);
    element_q.push_back(32'h0000_0003);
    element_q.push_back(32'h0000_0004);
    element_q.push_back(32'hffff_ffff);
    element_q.push_back(32'h8000_0000);
    wait_drained();

    // exclusive reverse
    configure(16'd1, 16'd3, 16'd1, 1'b1, 1'b0, 1'b1);
    @(negedge clk_i);
    element_q.push_back(32'h0000_0007);
    element_q.push_back(32'h7fff_ffff);
    element_q.push_back(32'h0000_0002);
    wait_drained();

    // zero geometry acts as one
    configure(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    @(negedge clk_i);
    element_q.push_back(32'h1234_5678);
    element_q.push_back(32'hedcb_a988);
    wait_drained();

    // oversized inner clamps to the memory depth; stray indexes keep the position
    configure(16'd1, 16'd2, 16'hffff, 1'b0, 1'b0, 1'b0);
    @(negedge clk_i);
    element_q.push_back(32'h0000_0001);
    element_q.push_back(32'h0000_0002);
    wait_drained();
    write_reg(CFG_UNMAPPED_6, 16'hffff);
    write_reg(CFG_UNMAPPED_7, 16'h5a5a);
    @(negedge clk_i);
    element_q.push_back(32'h0000_0003);
    element_q.push_back(32'h8000_0000);
    wait_drained();

    // extremes of the geometry
    configure(16'hffff, 16'd1, 16'd1, 1'b0, 1'b0, 1'b1);
    feed_random(200, 1);
    wait_drained();
    configure(16'd1, 16'hffff, 16'h0100, 1'b0, 1'b1, 1'b1);
    feed_random(300, 2);
    wait_drained();

    // long sink stall while the source keeps offering, then a full drain mid-tensor
    configure(16'd2, 16'd8, 16'd32, 1'b0, 1'b1, 1'b0);
    @(negedge clk_i);
    long_hold_req = 1'b1;
    feed_random(600, 0);
    wait_drained();
    feed_random(200, 0);
    wait_drained();

    while (total_fed < RANDOM_ITEMS) begin
      ns = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      ni = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      nr = (ni > 8) ? $urandom_range(1, 2) : $urandom_range(0, 5);
      configure(16'(ns), 16'(nr), {7'($urandom()), 9'(ni)},
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      size = ((ns == 0) ? 1 : ns) * ((nr == 0) ? 1 : nr) * ((ni == 0) ? 1 : ni);
      n = size * $urandom_range(1, 2);
      // a partial tensor now and then, cut short by the next register write
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, size);
      if (int'(n) > RANDOM_ITEMS - total_fed) n = unsigned'(RANDOM_ITEMS - total_fed);
      if ($urandom_range(0, 5) == 0) begin
        feed_random(n / 2, (RANDOM_ITEMS - total_fed < 300) ? 0 : $urandom_range(0, 2));
        wait_drained();
        n -= n / 2;
      end
      feed_random(n, (RANDOM_ITEMS - total_fed < 300) ? 0 : $urandom_range(0, 2));
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (pending_sums.size() != 0) begin
      $error("%0d result beats never arrived", pending_sums.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_strided_axis_prefix_sum OK");
    end else begin
      $display("tb_strided_axis_prefix_sum NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spx_pkg.sv
rtl/spx_sum_ram.sv
rtl/spx_addr_gen.sv
rtl/spx_out_buf.sv
rtl/strided_axis_prefix_sum.sv
rtl/spx_checker.sv
verif/tb_strided_axis_prefix_sum.sv
